@@ design/buck_voltage_pid_duty_defines.svh @@
// Assertion macros shared by the buck duty controller RTL.
`ifndef BUCK_VOLTAGE_PID_DUTY_DEFINES_SVH
`define BUCK_VOLTAGE_PID_DUTY_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BVPD_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BVPD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bvpd_pkg.sv @@
// Types, constants and the control program of the buck duty controller.
`default_nettype none

package bvpd_pkg;

    // Field and datapath widths.
    localparam int DUTY_BITS      = 12;
    localparam int VOLT_FRAC_BITS = 16;
    localparam int FB_MV_BITS     = 12;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int COEF_BITS      = 32;
    localparam int OPND_BITS      = 33;
    localparam int PROD_BITS      = 2 * OPND_BITS;
    localparam int ACC_BITS       = 74;
    localparam int HIST_BITS      = 40;
    localparam int ERR_BITS       = 22;
    localparam int PC_BITS        = 5;
    localparam int TDATA_BITS     = 16;

    localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;

    // Operating modes.
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_FIXED = 2'd1,
        MODE_PID   = 2'd2,
        MODE_FAULT = 2'd3
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MODE     = 3'd0,
        REG_PERCENT  = 3'd1,
        REG_SETPOINT = 3'd2,
        REG_B0       = 3'd3,
        REG_B1       = 3'd4,
        REG_B2       = 3'd5,
        REG_A1       = 3'd6,
        REG_A2       = 3'd7
    } reg_idx_t;

    // Coefficient reset values, signed Q2.30.
    localparam logic signed [COEF_BITS-1:0] B0_RESET = 32'sd536870912;
    localparam logic signed [COEF_BITS-1:0] B1_RESET = -32'sd1002337993;
    localparam logic signed [COEF_BITS-1:0] B2_RESET = 32'sd465676460;
    localparam logic signed [COEF_BITS-1:0] A1_RESET = -32'sd2144262423;
    localparam logic signed [COEF_BITS-1:0] A2_RESET = 32'sd1070520599;

    // Multiplier constants. The reciprocals are exact floors over the operand ranges used:
    // mv * ceil(2^32/125) >> 19 is floor(mv * 2^16 / 1000),
    // t * ceil(2^17/3) >> 17 is floor(t / 3) for t below 2^17,
    // x * ceil(2^26/100) >> 26 is floor(x / 100) for x below 2^20.
    localparam logic signed [OPND_BITS-1:0] RECIP_1000 = 33'sd34359739;
    localparam logic signed [OPND_BITS-1:0] RECIP_3    = 33'sd43691;
    localparam logic signed [OPND_BITS-1:0] RECIP_100  = 33'sd671089;

    // Linearization polynomial, Q30 coefficients.
    localparam logic signed [OPND_BITS-1:0] POLY_C1 = 33'sd3959208228;
    localparam logic signed [OPND_BITS-1:0] POLY_C2 = -33'sd15676631;
    localparam logic signed [OPND_BITS-1:0] POLY_C3 = -33'sd6227703;
    localparam logic signed [ACC_BITS-1:0]  POLY_C0_TERM = 74'sd35218732 <<< VOLT_FRAC_BITS;

    // Feedback clamp at 12 V, and the duty scale denominator (the same value).
    localparam logic [19:0] FB_MAX = 20'd786432;
    localparam logic signed [OPND_BITS-1:0] NEG_DUTY_LIMIT = -33'sd786432;
    // floor(t / 3) exceeds the duty range from this quotient of 2^18 upward.
    localparam logic [13:0] T_CLAMP = 14'd12288;

    // Output history saturation bounds.
    localparam logic signed [HIST_BITS-1:0] HIST_MAX = {1'b0, {(HIST_BITS-1){1'b1}}};
    localparam logic signed [HIST_BITS-1:0] HIST_MIN = {1'b1, {(HIST_BITS-1){1'b0}}};

    // Multiplier operand A sources.
    typedef enum logic [3:0] {
        OPA_ZERO, OPA_MV, OPA_V, OPA_V2, OPA_V3, OPA_E, OPA_E1, OPA_E2,
        OPA_Y1L, OPA_Y1H, OPA_Y2L, OPA_Y2H, OPA_T, OPA_PCT
    } opa_t;

    // Multiplier operand B sources.
    typedef enum logic [3:0] {
        OPB_ZERO, OPB_R1000, OPB_V, OPB_C1, OPB_C2, OPB_C3, OPB_B0, OPB_B1,
        OPB_B2, OPB_NA1, OPB_NA2, OPB_R3, OPB_R100
    } opb_t;

    // Datapath actions; those that use the product take the one registered by the step before.
    typedef enum logic [3:0] {
        ACT_NOP, ACT_WB_V, ACT_WB_V2, ACT_WB_V3, ACT_ACC_LDC0, ACT_ACC_LD,
        ACT_ACC_ADD, ACT_ACC_ADDH, ACT_ERR, ACT_YSAT, ACT_SCALE,
        ACT_FIN_PID, ACT_FIN_FIX, ACT_FIN_ZERO, ACT_FIN_HOLD
    } act_t;

    // Sequencing: next step, multiway jump on the mode, or end of program.
    typedef enum logic [1:0] {
        BR_SEQ, BR_MODE, BR_END
    } br_t;

    typedef struct packed {
        opa_t opa;
        opb_t opb;
        act_t act;
        br_t  br;
    } ucode_t;

    // Program entry points.
    localparam logic [PC_BITS-1:0] PC_START = 5'd0;
    localparam logic [PC_BITS-1:0] PC_PID   = 5'd1;
    localparam logic [PC_BITS-1:0] PC_IDLE  = 5'd21;
    localparam logic [PC_BITS-1:0] PC_HOLD  = 5'd22;
    localparam logic [PC_BITS-1:0] PC_FIX   = 5'd23;
    localparam logic [PC_BITS-1:0] PC_LAST  = 5'd24;

    function automatic ucode_t uw(opa_t a, opb_t b, act_t c, br_t d);
        return '{opa: a, opb: b, act: c, br: d};
    endfunction

    // Control store.
    function automatic ucode_t ucode_rom(logic [PC_BITS-1:0] pc);
        ucode_t w;
        case (pc)
            // Scale millivolts to Q16 volts, then dispatch on the mode.
            5'd0:  w = uw(OPA_MV,   OPB_R1000, ACT_NOP,      BR_MODE);
            // Cubic linearization.
            5'd1:  w = uw(OPA_ZERO, OPB_ZERO,  ACT_WB_V,     BR_SEQ);
            5'd2:  w = uw(OPA_V,    OPB_V,     ACT_NOP,      BR_SEQ);
            5'd3:  w = uw(OPA_V,    OPB_C1,    ACT_WB_V2,    BR_SEQ);
            5'd4:  w = uw(OPA_V2,   OPB_V,     ACT_ACC_LDC0, BR_SEQ);
            5'd5:  w = uw(OPA_V2,   OPB_C2,    ACT_WB_V3,    BR_SEQ);
            5'd6:  w = uw(OPA_V3,   OPB_C3,    ACT_ACC_ADD,  BR_SEQ);
            5'd7:  w = uw(OPA_ZERO, OPB_ZERO,  ACT_ACC_ADD,  BR_SEQ);
            5'd8:  w = uw(OPA_ZERO, OPB_ZERO,  ACT_ERR,      BR_SEQ);
            // Second-order section; output history terms split in 20-bit halves.
            5'd9:  w = uw(OPA_E,    OPB_B0,    ACT_NOP,      BR_SEQ);
            5'd10: w = uw(OPA_E1,   OPB_B1,    ACT_ACC_LD,   BR_SEQ);
            5'd11: w = uw(OPA_E2,   OPB_B2,    ACT_ACC_ADD,  BR_SEQ);
            5'd12: w = uw(OPA_Y1L,  OPB_NA1,   ACT_ACC_ADD,  BR_SEQ);
            5'd13: w = uw(OPA_Y1H,  OPB_NA1,   ACT_ACC_ADD,  BR_SEQ);
            5'd14: w = uw(OPA_Y2L,  OPB_NA2,   ACT_ACC_ADDH, BR_SEQ);
            5'd15: w = uw(OPA_Y2H,  OPB_NA2,   ACT_ACC_ADD,  BR_SEQ);
            5'd16: w = uw(OPA_ZERO, OPB_ZERO,  ACT_ACC_ADDH, BR_SEQ);
            5'd17: w = uw(OPA_ZERO, OPB_ZERO,  ACT_YSAT,     BR_SEQ);
            // Duty scaling and clamp.
            5'd18: w = uw(OPA_ZERO, OPB_ZERO,  ACT_SCALE,    BR_SEQ);
            5'd19: w = uw(OPA_T,    OPB_R3,    ACT_NOP,      BR_SEQ);
            5'd20: w = uw(OPA_ZERO, OPB_ZERO,  ACT_FIN_PID,  BR_END);
            // Idle and fault.
            5'd21: w = uw(OPA_ZERO, OPB_ZERO,  ACT_FIN_ZERO, BR_END);
            5'd22: w = uw(OPA_ZERO, OPB_ZERO,  ACT_FIN_HOLD, BR_END);
            // Fixed duty.
            5'd23: w = uw(OPA_PCT,  OPB_R100,  ACT_NOP,      BR_SEQ);
            5'd24: w = uw(OPA_ZERO, OPB_ZERO,  ACT_FIN_FIX,  BR_END);
            default: w = uw(OPA_ZERO, OPB_ZERO, ACT_FIN_ZERO, BR_END);
        endcase
        return w;
    endfunction

    // Entry point of each mode's program.
    function automatic logic [PC_BITS-1:0] mode_entry(mode_t m);
        logic [PC_BITS-1:0] pc;
        unique case (m)
            MODE_IDLE:  pc = PC_IDLE;
            MODE_FIXED: pc = PC_FIX;
            MODE_PID:   pc = PC_PID;
            MODE_FAULT: pc = PC_HOLD;
        endcase
        return pc;
    endfunction

endpackage

`default_nettype wire

@@ design/buck_voltage_pid_duty.sv @@
// Buck converter duty controller: microcoded sequencer around one shared multiplier.
//
// Usage. Each control tick is one beat on the s_ channel carrying the measured
// feedback in millivolts; each tick gives exactly one beat on the m_ channel
// with the 12-bit PWM duty and a flag that is set when the PID duty was
// clamped. Registers are written through cfg_wr_en / cfg_index / cfg_wdata
// while no tick is in progress.
// m_tvalid is set by the final step of the program for the current mode.
// s_tready is high whenever the sequencer is not running a program, so
// ticks are taken one at a time. The PID program runs 21 steps through the
// single 33 x 33 multiplier and the 74-bit accumulator.
// Reset (aresetn low, synchronous) loads the register defaults, clears the
// error and output histories and the last duty, and empties the output stage.
// A result waits in the output register while m_tready is low; a new tick
// may be accepted meanwhile, and its program stalls on its final step until
// the waiting beat is taken.
`default_nettype none
`include "buck_voltage_pid_duty_defines.svh"

module buck_voltage_pid_duty (
    input  logic        aclk,
    input  logic        aresetn,
    // Input beats.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] sense_mv, [15:12] zero
    // Result beats.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] duty, [15:12] zero
    output logic [0:0]  m_tuser,   // [0] duty_clamped
    // Register writes.
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    // Configuration registers.
    bvpd_pkg::mode_t mode_reg;
    logic [6:0]      pct_reg;
    logic [3:0]      setpoint_reg;
    logic signed [bvpd_pkg::COEF_BITS-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;

    // Sequencer.
    logic                         busy_reg, busy_next;
    logic [bvpd_pkg::PC_BITS-1:0] pc_reg, pc_next;
    bvpd_pkg::ucode_t             uc;
    logic                         fin_step, advance, step_en, in_beat;

    // Datapath.
    logic [bvpd_pkg::FB_MV_BITS-1:0]        feed_reg;
    logic signed [bvpd_pkg::OPND_BITS-1:0]  opnd_a, opnd_b;
    logic signed [bvpd_pkg::PROD_BITS-1:0]  prod_reg, prod_next;
    logic signed [bvpd_pkg::ACC_BITS-1:0]   acc_reg, prod_ext, prod_hi;
    logic [18:0]                            v_reg;
    logic [20:0]                            v2_reg;
    logic [22:0]                            v3_reg;
    logic signed [bvpd_pkg::ERR_BITS-1:0]   e_reg, e1_reg, e2_reg, e_next;
    logic signed [bvpd_pkg::HIST_BITS-1:0]  y_reg, y1_reg, y2_reg, y_next;
    logic [13:0]                            t_reg, t_next;
    logic                                   clamp_hi_reg, clamp_lo_reg;
    logic                                   clamp_hi_next, clamp_lo_next;
    logic [18:0]                            pct_scaled;
    logic signed [bvpd_pkg::OPND_BITS-1:0]  neg_a1, neg_a2;

    // Error and scale intermediates.
    logic signed [43:0]                     fb_q, ys;
    logic [19:0]                            fb;
    logic                                   big_pos, big_neg, in_range, hi_t;
    logic signed [bvpd_pkg::OPND_BITS-1:0]  y_mid, p_scaled;
    logic [13:0]                            t_full;
    logic [12:0]                            fix_q;

    // Finish and output stage.
    logic [bvpd_pkg::DUTY_BITS-1:0] fin_duty, last_duty_reg, duty_out_reg;
    logic                           fin_clamp, clamp_out_reg, m_tvalid_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= bvpd_pkg::MODE_IDLE;
            pct_reg      <= '0;
            setpoint_reg <= '0;
            b0_reg       <= bvpd_pkg::B0_RESET;
            b1_reg       <= bvpd_pkg::B1_RESET;
            b2_reg       <= bvpd_pkg::B2_RESET;
            a1_reg       <= bvpd_pkg::A1_RESET;
            a2_reg       <= bvpd_pkg::A2_RESET;
        end else if (cfg_wr_en) begin
            unique case (bvpd_pkg::reg_idx_t'(cfg_index))
                bvpd_pkg::REG_MODE:     mode_reg     <= bvpd_pkg::mode_t'(cfg_wdata[1:0]);
                bvpd_pkg::REG_PERCENT:  pct_reg      <= cfg_wdata[6:0];
                bvpd_pkg::REG_SETPOINT: setpoint_reg <= cfg_wdata[3:0];
                bvpd_pkg::REG_B0:       b0_reg       <= cfg_wdata;
                bvpd_pkg::REG_B1:       b1_reg       <= cfg_wdata;
                bvpd_pkg::REG_B2:       b2_reg       <= cfg_wdata;
                bvpd_pkg::REG_A1:       a1_reg       <= cfg_wdata;
                bvpd_pkg::REG_A2:       a2_reg       <= cfg_wdata;
            endcase
        end
    end

    // Step control: the final step waits while an earlier result is still held.
    assign uc       = bvpd_pkg::ucode_rom(pc_reg);
    assign fin_step = (uc.br == bvpd_pkg::BR_END);
    assign advance  = !(fin_step && m_tvalid_reg && !m_tready);
    assign step_en  = busy_reg && advance;
    assign s_tready = !busy_reg;
    assign in_beat  = s_tvalid && s_tready;

    always_comb begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (in_beat) begin
            busy_next = 1'b1;
            pc_next   = bvpd_pkg::PC_START;
        end else if (step_en) begin
            unique case (uc.br)
                bvpd_pkg::BR_SEQ:  pc_next = pc_reg + 1'b1;
                bvpd_pkg::BR_MODE: pc_next = bvpd_pkg::mode_entry(mode_reg);
                bvpd_pkg::BR_END:  busy_next = 1'b0;
                default:           busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pc_reg   <= bvpd_pkg::PC_START;
        end else begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    // Operand A select.
    assign pct_scaled = {pct_reg, 12'b0} - {12'b0, pct_reg};

    always_comb begin
        case (uc.opa)
            bvpd_pkg::OPA_MV:  opnd_a = $signed({21'b0, feed_reg});
            bvpd_pkg::OPA_V:   opnd_a = $signed({14'b0, v_reg});
            bvpd_pkg::OPA_V2:  opnd_a = $signed({12'b0, v2_reg});
            bvpd_pkg::OPA_V3:  opnd_a = $signed({10'b0, v3_reg});
            bvpd_pkg::OPA_E:   opnd_a = $signed({{11{e_reg[21]}}, e_reg});
            bvpd_pkg::OPA_E1:  opnd_a = $signed({{11{e1_reg[21]}}, e1_reg});
            bvpd_pkg::OPA_E2:  opnd_a = $signed({{11{e2_reg[21]}}, e2_reg});
            bvpd_pkg::OPA_Y1L: opnd_a = $signed({13'b0, y1_reg[19:0]});
            bvpd_pkg::OPA_Y1H: opnd_a = $signed({{13{y1_reg[39]}}, y1_reg[39:20]});
            bvpd_pkg::OPA_Y2L: opnd_a = $signed({13'b0, y2_reg[19:0]});
            bvpd_pkg::OPA_Y2H: opnd_a = $signed({{13{y2_reg[39]}}, y2_reg[39:20]});
            bvpd_pkg::OPA_T:   opnd_a = $signed({19'b0, t_reg});
            bvpd_pkg::OPA_PCT: opnd_a = $signed({14'b0, pct_scaled});
            default:           opnd_a = '0;
        endcase
    end

    // Operand B select; the denominator terms enter negated.
    assign neg_a1 = 33'sd0 - $signed({a1_reg[31], a1_reg});
    assign neg_a2 = 33'sd0 - $signed({a2_reg[31], a2_reg});

    always_comb begin
        case (uc.opb)
            bvpd_pkg::OPB_R1000: opnd_b = bvpd_pkg::RECIP_1000;
            bvpd_pkg::OPB_V:     opnd_b = $signed({14'b0, v_reg});
            bvpd_pkg::OPB_C1:    opnd_b = bvpd_pkg::POLY_C1;
            bvpd_pkg::OPB_C2:    opnd_b = bvpd_pkg::POLY_C2;
            bvpd_pkg::OPB_C3:    opnd_b = bvpd_pkg::POLY_C3;
            bvpd_pkg::OPB_B0:    opnd_b = $signed({b0_reg[31], b0_reg});
            bvpd_pkg::OPB_B1:    opnd_b = $signed({b1_reg[31], b1_reg});
            bvpd_pkg::OPB_B2:    opnd_b = $signed({b2_reg[31], b2_reg});
            bvpd_pkg::OPB_NA1:   opnd_b = neg_a1;
            bvpd_pkg::OPB_NA2:   opnd_b = neg_a2;
            bvpd_pkg::OPB_R3:    opnd_b = bvpd_pkg::RECIP_3;
            bvpd_pkg::OPB_R100:  opnd_b = bvpd_pkg::RECIP_100;
            default:             opnd_b = '0;
        endcase
    end

    // The shared multiplier, registered.
    assign prod_next = opnd_a * opnd_b;
    assign prod_ext  = {{(bvpd_pkg::ACC_BITS - bvpd_pkg::PROD_BITS){prod_reg[65]}}, prod_reg};
    assign prod_hi   = prod_ext <<< 20;

    // Feedback floor to Q16, clamp to the 0..12 V window, and error.
    always_comb begin
        fb_q = acc_reg[73:30];
        if (fb_q[43]) begin
            fb = '0;
        end else if (fb_q > $signed({24'b0, bvpd_pkg::FB_MAX})) begin
            fb = bvpd_pkg::FB_MAX;
        end else begin
            fb = fb_q[19:0];
        end
        e_next = $signed({2'b00, setpoint_reg, 16'h0000}) - $signed({2'b00, fb});
    end

    // Controller output floor to Q16 and saturation to the history width.
    always_comb begin
        ys = acc_reg[73:30];
        if (!ys[43] && (ys[42:39] != 4'h0)) begin
            y_next = bvpd_pkg::HIST_MAX;
        end else if (ys[43] && (ys[42:39] != 4'hF)) begin
            y_next = bvpd_pkg::HIST_MIN;
        end else begin
            y_next = ys[39:0];
        end
    end

    // Duty scaling: y * 4095 / (3 * 2^18), the last divide by 3 done on the multiplier.
    always_comb begin
        big_pos  = !y_reg[39] && (|y_reg[38:20]);
        big_neg  = y_reg[39] && !(&y_reg[38:20]);
        in_range = !big_pos && !big_neg;
        y_mid    = $signed({{12{y_reg[20]}}, y_reg[20:0]});
        p_scaled = (y_mid <<< 12) - y_mid;
        t_full   = p_scaled[31:18];
        hi_t     = (t_full >= bvpd_pkg::T_CLAMP);
        clamp_hi_next = big_pos || (in_range && !p_scaled[32] && hi_t);
        clamp_lo_next = big_neg ||
                        (in_range && p_scaled[32] && (p_scaled <= bvpd_pkg::NEG_DUTY_LIMIT));
        t_next   = (in_range && !p_scaled[32] && !hi_t) ? t_full : 14'd0;
    end

    // Result of the finishing step.
    assign fix_q = prod_reg[38:26];

    always_comb begin
        fin_duty  = '0;
        fin_clamp = 1'b0;
        case (uc.act)
            bvpd_pkg::ACT_FIN_PID: begin
                fin_clamp = clamp_hi_reg || clamp_lo_reg;
                if (clamp_hi_reg) begin
                    fin_duty = bvpd_pkg::DUTY_MAX;
                end else if (clamp_lo_reg) begin
                    fin_duty = '0;
                end else begin
                    fin_duty = prod_reg[28:17];
                end
            end
            bvpd_pkg::ACT_FIN_FIX: begin
                fin_duty = fix_q[12] ? bvpd_pkg::DUTY_MAX : fix_q[11:0];
            end
            bvpd_pkg::ACT_FIN_HOLD: fin_duty = last_duty_reg;
            default:                fin_duty = '0;
        endcase
    end

    // Datapath registers, updated by the current control word.
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            feed_reg <= s_tdata[11:0];
        end
        if (step_en) begin
            prod_reg <= prod_next;
            case (uc.act)
                bvpd_pkg::ACT_WB_V:     v_reg   <= prod_reg[37:19];
                bvpd_pkg::ACT_WB_V2:    v2_reg  <= prod_reg[36:16];
                bvpd_pkg::ACT_WB_V3:    v3_reg  <= prod_reg[38:16];
                bvpd_pkg::ACT_ACC_LDC0: acc_reg <= bvpd_pkg::POLY_C0_TERM + prod_ext;
                bvpd_pkg::ACT_ACC_LD:   acc_reg <= prod_ext;
                bvpd_pkg::ACT_ACC_ADD:  acc_reg <= acc_reg + prod_ext;
                bvpd_pkg::ACT_ACC_ADDH: acc_reg <= acc_reg + prod_hi;
                bvpd_pkg::ACT_ERR:      e_reg   <= e_next;
                bvpd_pkg::ACT_YSAT:     y_reg   <= y_next;
                bvpd_pkg::ACT_SCALE: begin
                    t_reg        <= t_next;
                    clamp_hi_reg <= clamp_hi_next;
                    clamp_lo_reg <= clamp_lo_next;
                end
                default: ;
            endcase
        end
    end

    // Histories and last duty; only a PID tick shifts the histories.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_reg        <= '0;
            e2_reg        <= '0;
            y1_reg        <= '0;
            y2_reg        <= '0;
            last_duty_reg <= '0;
        end else if (step_en && fin_step) begin
            last_duty_reg <= fin_duty;
            if (uc.act == bvpd_pkg::ACT_FIN_PID) begin
                e2_reg <= e1_reg;
                e1_reg <= e_reg;
                y2_reg <= y1_reg;
                y1_reg <= y_reg;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (step_en && fin_step) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && fin_step) begin
            duty_out_reg  <= fin_duty;
            clamp_out_reg <= fin_clamp;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, duty_out_reg};
    assign m_tuser  = clamp_out_reg;

    // Checks.
    `BVPD_ASSERT_NEXT(a_start_at_entry, in_beat,
        busy_reg && (pc_reg == bvpd_pkg::PC_START),
        "tick did not start the program at its entry")
    `BVPD_ASSERT_NOW(a_pc_in_program, busy_reg, pc_reg <= bvpd_pkg::PC_LAST,
        "program counter left the control store")
    `BVPD_ASSERT_NEXT(a_final_step_waits,
        busy_reg && fin_step && m_tvalid_reg && !m_tready,
        busy_reg && $stable(pc_reg),
        "final step did not wait for the held result")
    `BVPD_ASSERT_NOW(a_clamp_flags_excl,
        busy_reg && (uc.act == bvpd_pkg::ACT_FIN_PID),
        !(clamp_hi_reg && clamp_lo_reg),
        "duty clamped both high and low")
    `BVPD_ASSERT_NOW(a_clamped_at_limit, m_tvalid_reg && clamp_out_reg,
        (duty_out_reg == '0) || (duty_out_reg == bvpd_pkg::DUTY_MAX),
        "clamp flag set on a duty inside the range")

endmodule

`default_nettype wire
